// ----- sv/kfc_pkg.sv -----
package kfc_pkg;

	localparam int unsigned MAX_PAYLOAD = 100;
	localparam logic [7:0] POS_MAX = 8'd255;
	localparam logic [7:0] POS_PAYLOAD_START = 8'd2;

	typedef struct packed {
		logic       is_status;
		logic [7:0] payload_byte;
		logic [6:0] payload_index;
		logic [7:0] header_code;
		logic [6:0] payload_count;
		logic       checksum_ok;
		logic       short_frame;
	} result_t;

endpackage

// ----- sv/kfc_frame_core.sv -----
module kfc_frame_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        rx_byte,
	input  logic              end_of_frame,
	output logic              res_valid,
	output kfc_pkg::result_t  res
);

	logic [7:0] byte_position_q;
	logic [7:0] running_sum_q;
	logic [7:0] captured_header_q;
	logic [6:0] kept_count_q;

	logic [7:0] sum_next;
	logic [7:0] header_now;
	logic       keep_byte;

	assign sum_next   = running_sum_q + rx_byte;
	assign header_now = (byte_position_q == 8'd0) ? rx_byte : captured_header_q;
	assign keep_byte  = (byte_position_q >= kfc_pkg::POS_PAYLOAD_START) &&
		(kept_count_q < 7'(kfc_pkg::MAX_PAYLOAD));

	always_comb begin
		res = '0;
		res_valid = 1'b0;
		if (end_of_frame) begin
			res_valid         = fire;
			res.is_status     = 1'b1;
			res.header_code   = header_now;
			res.payload_count = kept_count_q;
			res.checksum_ok   = (sum_next == 8'd0);
			res.short_frame   = (byte_position_q < kfc_pkg::POS_PAYLOAD_START);
		end else if (keep_byte) begin
			res_valid         = fire;
			res.payload_byte  = rx_byte;
			res.payload_index = kept_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q   <= '0;
			running_sum_q     <= '0;
			captured_header_q <= '0;
			kept_count_q      <= '0;
		end else if (fire) begin
			if (end_of_frame) begin
				byte_position_q   <= '0;
				running_sum_q     <= '0;
				captured_header_q <= '0;
				kept_count_q      <= '0;
			end else begin
				running_sum_q     <= sum_next;
				captured_header_q <= header_now;
				if (byte_position_q != kfc_pkg::POS_MAX) begin
					byte_position_q <= byte_position_q + 8'd1;
				end
				if (keep_byte) begin
					kept_count_q <= kept_count_q + 7'd1;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= 7'(kfc_pkg::MAX_PAYLOAD))
		else $error("kept count exceeds the payload limit");

	a_clear_after_status: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_of_frame) |=> (byte_position_q == 8'd0 && kept_count_q == 7'd0 &&
		running_sum_q == 8'd0))
		else $error("frame state not cleared after the last beat");
`endif

endmodule

// ----- sv/kfc_out_buffer.sv -----
module kfc_out_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kfc_pkg::result_t  push_data,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output kfc_pkg::result_t  out_data
);

	logic             out_valid_q;
	logic             skid_valid_q;
	kfc_pkg::result_t out_data_q;
	kfc_pkg::result_t skid_data_q;

	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

`ifndef ASSERT_OFF
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while the output register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("beat pushed into a full output buffer");
`endif

endmodule

// ----- sv/kline_frame_checker.sv -----
// Path: a result beat is registered in the input register and then in the output
// buffer before it is presented.
// Throughput: one input beat per cycle, independent of the output side while
// the two-entry output buffer has room; the input register, the frame state
// update and the output buffer are the stages in the path.
// Reset: arst_n clears the frame state and all valid flags asynchronously.
module kline_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_status,
	output logic [7:0] payload_byte,
	output logic [6:0] payload_index,
	output logic [7:0] header_code,
	output logic [6:0] payload_count,
	output logic       checksum_ok,
	output logic       short_frame
);

	logic             valid_s1;
	logic [7:0]       rx_byte_s1;
	logic             end_of_frame_s1;
	logic             can_push;
	logic             fire;
	logic             res_valid;
	kfc_pkg::result_t res;
	kfc_pkg::result_t out_data;

	assign fire     = valid_s1 && can_push;
	assign in_ready = !valid_s1 || can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1      <= rx_byte;
			end_of_frame_s1 <= end_of_frame;
		end
	end

	kfc_frame_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.rx_byte      (rx_byte_s1),
		.end_of_frame (end_of_frame_s1),
		.res_valid    (res_valid),
		.res          (res)
	);

	kfc_out_buffer u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign is_status     = out_data.is_status;
	assign payload_byte  = out_data.payload_byte;
	assign payload_index = out_data.payload_index;
	assign header_code   = out_data.header_code;
	assign payload_count = out_data.payload_count;
	assign checksum_ok   = out_data.checksum_ok;
	assign short_frame   = out_data.short_frame;

endmodule

// ----- tb/tb.sv -----
module tb;

	class frame_scoreboard;
		logic [7:0]       position;
		logic [7:0]       byte_sum;
		logic [7:0]       header;
		logic [6:0]       kept;
		kfc_pkg::result_t expected_results[$];
		int               errors;

		function new();
			position = '0;
			byte_sum = '0;
			header = '0;
			kept = '0;
			errors = 0;
		endfunction

		function void note_beat(logic [7:0] rx, logic last);
			kfc_pkg::result_t r;
			logic [7:0]       pos;
			logic [7:0]       total;
			pos = position;
			total = byte_sum + rx;
			r = '0;
			if (pos == 8'd0)
				header = rx;
			if (last) begin
				r.is_status = 1'b1;
				r.header_code = header;
				r.payload_count = kept;
				r.checksum_ok = (total == 8'd0);
				r.short_frame = (pos < kfc_pkg::POS_PAYLOAD_START);
				expected_results.push_back(r);
				position = '0;
				byte_sum = '0;
				header = '0;
				kept = '0;
				return;
			end
			byte_sum = total;
			if (position != kfc_pkg::POS_MAX)
				position = position + 8'd1;
			if (pos >= kfc_pkg::POS_PAYLOAD_START && kept < kfc_pkg::MAX_PAYLOAD) begin
				r.payload_byte = rx;
				r.payload_index = kept;
				expected_results.push_back(r);
				kept = kept + 7'd1;
			end
		endfunction

		function void compare_field(string name, int exp_val, int act_val);
			if (exp_val != act_val) begin
				$error("%s: expected %0d, got %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_result(kfc_pkg::result_t act);
			kfc_pkg::result_t e;
			if (expected_results.size() == 0) begin
				$error("result beat arrived with nothing expected");
				errors++;
				return;
			end
			e = expected_results.pop_front();
			compare_field("is_status", e.is_status, act.is_status);
			compare_field("payload_byte", e.payload_byte, act.payload_byte);
			compare_field("payload_index", e.payload_index, act.payload_index);
			compare_field("header_code", e.header_code, act.header_code);
			compare_field("payload_count", e.payload_count, act.payload_count);
			compare_field("checksum_ok", e.checksum_ok, act.checksum_ok);
			compare_field("short_frame", e.short_frame, act.short_frame);
		endfunction
	endclass

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BEATS = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       end_of_frame = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_status;
	logic [7:0] payload_byte;
	logic [6:0] payload_index;
	logic [7:0] header_code;
	logic [6:0] payload_count;
	logic       checksum_ok;
	logic       short_frame;

	frame_scoreboard sb = new();

	logic [7:0] frame_bytes[$];
	int         burst_left = 0;
	int         beats_sent = 0;
	int         idle_cycles = 0;
	int         cycle_count = 0;
	int         stall_mode = 0;
	int         stall_left = 0;

	kline_frame_checker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.end_of_frame(end_of_frame),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_status(is_status),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.header_code(header_code),
		.payload_count(payload_count),
		.checksum_ok(checksum_ok),
		.short_frame(short_frame)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 100);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (cycle_count % 8 == 0);
			default: out_ready <= (cycle_count % 4 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({is_status, payload_byte, payload_index, header_code,
				payload_count, checksum_ok, short_frame});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_beat(input logic [7:0] rx, input logic last);
		in_valid <= 1'b1;
		rx_byte <= rx;
		end_of_frame <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(rx, last);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic send_frame(input bit fix_sum);
		logic [7:0] total;
		int         i;
		total = 8'h00;
		if (fix_sum) begin
			for (i = 0; i < frame_bytes.size() - 1; i++)
				total = total + frame_bytes[i];
			frame_bytes[frame_bytes.size() - 1] = 8'h00 - total;
		end
		for (i = 0; i < frame_bytes.size(); i++)
			send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic random_frame(input int len, input bit fix_sum);
		int i;
		frame_bytes.delete();
		for (i = 0; i < len; i++)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		send_frame(fix_sum);
	endtask

	initial begin
		int len;
		bit long_done;
		long_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_bytes = '{8'h00};
		send_frame(1'b0);
		frame_bytes = '{8'hFF};
		send_frame(1'b0);
		frame_bytes = '{8'h81, 8'h00};
		send_frame(1'b1);
		frame_bytes = '{8'h12, 8'h34};
		send_frame(1'b0);
		frame_bytes = '{8'h80, 8'h01, 8'h00};
		send_frame(1'b1);
		frame_bytes = '{8'hFF, 8'h01, 8'h00};
		send_frame(1'b0);
		frame_bytes = '{8'hFF, 8'h03, 8'h00, 8'hFF, 8'h00};
		send_frame(1'b1);
		frame_bytes = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55};
		send_frame(1'b0);

		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			if (!long_done && beats_sent > RANDOM_BEATS / 3) begin
				long_done = 1'b1;
				random_frame(258, 1'b1);
			end
			case ($urandom_range(0, 9))
				0: len = $urandom_range(1, 2);
				1: len = $urandom_range(21, 40);
				default: len = $urandom_range(3, 20);
			endcase
			random_frame(len, $urandom_range(0, 3) != 0);
		end
		in_valid <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
